// ===== src/lbac_pkg.sv =====
// Shared types and constants for the LRU block address cache directory.
// Used by the controller, the datapath and the top level; depends on nothing.
package lbac_pkg;

	localparam int ADDR_W      = 48;
	localparam int CNT_W       = 32;
	localparam int SLOT_W      = 4;
	localparam int REQ_W       = 2;
	localparam int S_TDATA_W   = 48;
	localparam int M_TDATA_W   = 72;

	typedef enum logic [REQ_W-1:0] {
		REQ_LOOKUP = 2'd0,
		REQ_INSERT = 2'd1,
		REQ_INVAL  = 2'd2
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MATCH,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic match;
		logic commit;
	} lbac_cmd_t;

endpackage

// ===== src/lbac_ctrl.sv =====
// Controller state machine for the LRU block address cache directory.
// Sequences capture, match and commit and owns the result valid flag; uses lbac_pkg.
module lbac_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	output logic             m_tvalid,
	input  logic             m_tready,
	output lbac_pkg::lbac_cmd_t cmd
);
	import lbac_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   m_tvalid_q;
	logic   commit_ok;
	logic   accept;

	assign commit_ok = !m_tvalid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign m_tvalid  = m_tvalid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_MATCH;
			end
			ST_MATCH: begin
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				if (commit_ok) state_d = accept ? ST_MATCH : ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		cmd.match  = 1'b0;
		cmd.commit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_MATCH: begin
				cmd.match = 1'b1;
			end
			ST_COMMIT: begin
				// The next request may enter in the same cycle that this one commits.
				s_tready   = commit_ok;
				cmd.commit = commit_ok;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
		cmd.load = s_tvalid && s_tready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.commit) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	a_load_then_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_MATCH)
		else $error("accepted request did not enter the match step");

	a_match_then_commit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MATCH |=> state_q == ST_COMMIT)
		else $error("match step not followed by commit step");

	a_result_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid_q) |-> $past(cmd.commit))
		else $error("result appeared without a commit");

endmodule

// ===== src/lbac_datapath.sv =====
// Datapath of the LRU block address cache directory: tag, valid and rank
// registers, parallel match, victim select, counters and result register; uses lbac_pkg.
module lbac_datapath #(
	parameter int Entries = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  lbac_pkg::lbac_cmd_t                cmd,
	input  logic [lbac_pkg::REQ_W-1:0]         req_in,
	input  logic [lbac_pkg::ADDR_W-1:0]        addr_in,
	output logic [lbac_pkg::M_TDATA_W-1:0]     result
);
	import lbac_pkg::*;

	localparam int IW = (Entries > 1) ? $clog2(Entries) : 1;

	// Entry state.
	logic              valid_q [Entries];
	logic [ADDR_W-1:0] tag_q   [Entries];
	logic [IW-1:0]     rank_q  [Entries];
	logic [CNT_W-1:0]  hit_q;
	logic [CNT_W-1:0]  miss_q;

	// Captured request.
	logic [REQ_W-1:0]  req_s1;
	logic [ADDR_W-1:0] addr_s1;

	// Match results.
	logic [REQ_W-1:0]   req_s2;
	logic [ADDR_W-1:0]  addr_s2;
	logic               found_s2;
	logic [Entries-1:0] touch_oh_s2;
	logic [IW-1:0]      touch_idx_s2;
	logic [IW-1:0]      own_s2;

	// Result register.
	logic              found_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  hit_out_q;
	logic [CNT_W-1:0]  miss_out_q;

	logic [Entries-1:0] hit_vec;
	logic [Entries-1:0] free_vec;
	logic [Entries-1:0] lru_vec;
	logic [Entries-1:0] hit_oh;
	logic [Entries-1:0] free_oh;
	logic [Entries-1:0] lru_oh;
	logic [Entries-1:0] touch_oh;
	logic [IW-1:0]      touch_idx;
	logic [IW-1:0]      own_rank;
	logic               found;
	logic               any_hit;
	logic               touch_any;
	logic [CNT_W-1:0]   hit_d;
	logic [CNT_W-1:0]   miss_d;
	logic [IW+SLOT_W-1:0] slot_ext;

	always_comb begin
		for (int i = 0; i < Entries; i++) begin
			hit_vec[i]  = valid_q[i] && (tag_q[i] == addr_s1);
			free_vec[i] = !valid_q[i];
			lru_vec[i]  = (rank_q[i] == '0);
		end
		// Isolate the lowest set bit of each vector.
		hit_oh  = hit_vec & (~hit_vec + Entries'(1));
		free_oh = free_vec & (~free_vec + Entries'(1));
		lru_oh  = lru_vec & (~lru_vec + Entries'(1));
		any_hit = |hit_vec;

		found    = 1'b0;
		touch_oh = '0;
		case (req_s1) inside
			REQ_LOOKUP, REQ_INVAL: begin
				found    = any_hit;
				touch_oh = hit_oh;
			end
			REQ_INSERT: begin
				// With every entry valid the ranks form a permutation, so rank zero is unique.
				touch_oh = (|free_vec) ? free_oh : lru_oh;
			end
			default: begin
				touch_oh = '0;
			end
		endcase

		touch_idx = '0;
		own_rank  = '0;
		for (int i = 0; i < Entries; i++) begin
			touch_idx = touch_idx | (touch_oh[i] ? IW'(i) : '0);
			own_rank  = own_rank | (touch_oh[i] ? rank_q[i] : '0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_s1  <= req_in;
			addr_s1 <= addr_in;
		end
		if (cmd.match) begin
			req_s2       <= req_s1;
			addr_s2      <= addr_s1;
			found_s2     <= found;
			touch_oh_s2  <= touch_oh;
			touch_idx_s2 <= touch_idx;
			own_s2       <= own_rank;
		end
	end

	always_comb begin
		hit_d  = hit_q;
		miss_d = miss_q;
		if (req_s2 == REQ_LOOKUP) begin
			if (found_s2) begin
				if (hit_q != '1) hit_d = hit_q + CNT_W'(1);
			end else if (miss_q != '1) begin
				miss_d = miss_q + CNT_W'(1);
			end
		end
		touch_any = |touch_oh_s2;
		slot_ext  = {{SLOT_W{1'b0}}, touch_idx_s2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < Entries; i++) begin
				valid_q[i] <= 1'b0;
				rank_q[i]  <= '0;
			end
			hit_q  <= '0;
			miss_q <= '0;
		end else if (cmd.commit) begin
			hit_q  <= hit_d;
			miss_q <= miss_d;
			for (int i = 0; i < Entries; i++) begin
				if (touch_oh_s2[i]) begin
					rank_q[i] <= IW'(Entries - 1);
					if (req_s2 == REQ_INSERT) valid_q[i] <= 1'b1;
					else if (req_s2 == REQ_INVAL) valid_q[i] <= 1'b0;
				end else if (touch_any && rank_q[i] > own_s2) begin
					rank_q[i] <= rank_q[i] - IW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			for (int i = 0; i < Entries; i++) begin
				if (touch_oh_s2[i] && req_s2 == REQ_INSERT) tag_q[i] <= addr_s2;
			end
			found_q    <= found_s2;
			slot_q     <= slot_ext[SLOT_W-1:0];
			hit_out_q  <= hit_d;
			miss_out_q <= miss_d;
		end
	end

	assign result = {3'b000, miss_out_q, hit_out_q, slot_q, found_q};

	a_single_touch: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> $onehot0(touch_oh_s2))
		else $error("more than one entry selected for update");

	a_hits_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> hit_q >= $past(hit_q) && miss_q >= $past(miss_q))
		else $error("hit or miss counter went backwards");

	a_found_has_entry: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && found_s2 |-> touch_any)
		else $error("match reported without a selected entry");

endmodule

// ===== src/lru_block_address_cache.sv =====
// Top level of the LRU block address cache directory.
// Joins lbac_ctrl and lbac_datapath; uses lbac_pkg.
//
// A fully associative directory of 48-bit block addresses with least-recently-used
// replacement. Each request (tuser: 0 lookup, 1 insert, 2 invalidate) runs a match step
// and then an update step: in the match step all valid tags are compared in parallel and
// the lowest matching entry, or for an insert the lowest free entry or else the least
// recent one, is picked; in the update step the ranks, valid bits, tag and saturating
// hit/miss counters are updated and the result is loaded into the output register. A new
// request is taken in the update step, so it is captured while the last one updates if
// the result side keeps up; a stalled result holds the update step until it is taken.
module lru_block_address_cache #(
	parameter int ENTRIES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [lbac_pkg::S_TDATA_W-1:0] s_tdata,  // [47:0] block_addr
	input  logic [lbac_pkg::REQ_W-1:0]     s_tuser,  // [1:0] req_type
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [lbac_pkg::M_TDATA_W-1:0] m_tdata   // [0] found, [4:1] slot,
	                                                 // [36:5] hit_total,
	                                                 // [68:37] miss_total, rest zero
);
	import lbac_pkg::*;

	lbac_cmd_t cmd;

	lbac_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	lbac_datapath #(
		.Entries (ENTRIES)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.req_in  (s_tuser),
		.addr_in (s_tdata[ADDR_W-1:0]),
		.result  (m_tdata)
	);

endmodule
